/* rtl/core/psd_pkg.sv */
// Shared types and defaults for the point-to-segment distance unit.
package psd_pkg;

  // Default coordinate width (signed fixed point, any fraction width)
  localparam int unsigned COORD_BITS_DEF = 32;

  // Control that travels with each transaction through the front end and divider
  typedef struct packed {
    logic valid;
    logic sel_div;
  } ctl_t;

endpackage

/* rtl/core/psd_front.sv */
// Front end: differences, dot products, branch select and numerator square.
module psd_front import psd_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             in_valid_i,
  input  logic signed [COORD_BITS-1:0]     point_x_i,
  input  logic signed [COORD_BITS-1:0]     point_y_i,
  input  logic signed [COORD_BITS-1:0]     point_z_i,
  input  logic signed [COORD_BITS-1:0]     top_x_i,
  input  logic signed [COORD_BITS-1:0]     top_y_i,
  input  logic signed [COORD_BITS-1:0]     top_z_i,
  input  logic signed [COORD_BITS-1:0]     bottom_x_i,
  input  logic signed [COORD_BITS-1:0]     bottom_y_i,
  input  logic signed [COORD_BITS-1:0]     bottom_z_i,
  output ctl_t                             ctl_o,
  output logic [2*COORD_BITS+1:0]          a_o,
  output logic [2*COORD_BITS+1:0]          l_o,
  output logic [2*COORD_BITS+1:0]          direct_o,
  output logic [2*COORD_BITS+1:0]          rem_o,
  output logic [2*COORD_BITS+1:0]          nlow_o
);

  localparam int unsigned EW   = COORD_BITS + 1;  // difference width
  localparam int unsigned SQ_W = 2 * EW;          // squared-length width
  localparam int unsigned DW   = SQ_W + 1;        // signed dot product width
  localparam int unsigned HW   = SQ_W / 2;        // half of the dot product
  localparam int unsigned N_W  = 2 * SQ_W;        // dot product squared

  logic signed [COORD_BITS-1:0] p [3];
  logic signed [COORD_BITS-1:0] t [3];
  logic signed [COORD_BITS-1:0] b [3];

  assign p[0] = point_x_i;
  assign p[1] = point_y_i;
  assign p[2] = point_z_i;
  assign t[0] = top_x_i;
  assign t[1] = top_y_i;
  assign t[2] = top_z_i;
  assign b[0] = bottom_x_i;
  assign b[1] = bottom_y_i;
  assign b[2] = bottom_z_i;

  // Valid bits of the five stages
  logic v1_q, v2_q, v3_q;
  ctl_t ctl4_q, ctl4_d, ctl5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else if (en_i) begin
      v1_q   <= in_valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      ctl4_q <= ctl4_d;
      ctl5_q <= ctl4_q;
    end
  end

  // Stage 1: e = p - t, f = b - t, g = p - b
  logic signed [EW-1:0] e_d [3], f_d [3], g_d [3];
  logic signed [EW-1:0] e_q [3], f_q [3], g_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_d[i] = EW'(p[i]) - EW'(t[i]);
      f_d[i] = EW'(b[i]) - EW'(t[i]);
      g_d[i] = EW'(p[i]) - EW'(b[i]);
    end
  end

  // Stage 2: per-axis products
  logic signed [SQ_W-1:0] ee_d [3], ff_d [3], ef_d [3], gg_d [3];
  logic signed [SQ_W-1:0] ee_q [3], ff_q [3], ef_q [3], gg_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ee_d[i] = e_q[i] * e_q[i];
      ff_d[i] = f_q[i] * f_q[i];
      ef_d[i] = e_q[i] * f_q[i];
      gg_d[i] = g_q[i] * g_q[i];
    end
  end

  // Stage 3: sums over the axes
  logic [SQ_W-1:0]        a3_d, l3_d, g3_d;
  logic signed [DW-1:0]   d3_d;
  logic [SQ_W-1:0]        a3_q, l3_q, g3_q;
  logic signed [DW-1:0]   d3_q;

  assign a3_d = $unsigned(ee_q[0]) + $unsigned(ee_q[1]) + $unsigned(ee_q[2]);
  assign l3_d = $unsigned(ff_q[0]) + $unsigned(ff_q[1]) + $unsigned(ff_q[2]);
  assign g3_d = $unsigned(gg_q[0]) + $unsigned(gg_q[1]) + $unsigned(gg_q[2]);
  assign d3_d = DW'(ef_q[0]) + DW'(ef_q[1]) + DW'(ef_q[2]);

  // Stage 4: branch select and partial products of d*d
  logic             d_neg;
  logic [SQ_W-1:0]  d_mag;
  logic             l_zero;
  logic [SQ_W-1:0]  direct4_d;
  logic [SQ_W-1:0]  pp_ll_d, pp_lh_d, pp_hh_d;
  logic [SQ_W-1:0]  a4_q, l4_q, direct4_q;
  logic [SQ_W-1:0]  pp_ll_q, pp_lh_q, pp_hh_q;

  assign d_neg  = d3_q[DW-1];
  assign d_mag  = d3_q[SQ_W-1:0];
  assign l_zero = (l3_q == '0);

  always_comb begin
    ctl4_d.valid   = v3_q;
    ctl4_d.sel_div = !l_zero && !d_neg && (d_mag < l3_q);
    // behind top (or degenerate) -> distance to top, else distance to bottom
    direct4_d      = (l_zero || d_neg) ? a3_q : g3_q;
  end

  assign pp_ll_d = d_mag[HW-1:0]    * d_mag[HW-1:0];
  assign pp_lh_d = d_mag[HW-1:0]    * d_mag[SQ_W-1:HW];
  assign pp_hh_d = d_mag[SQ_W-1:HW] * d_mag[SQ_W-1:HW];

  // Stage 5: d*d assembled from the partial products
  logic [N_W-1:0]   n5_d, n5_q;
  logic [SQ_W-1:0]  a5_q, l5_q, direct5_q;

  assign n5_d = {pp_hh_q, SQ_W'(0)} + (N_W'(pp_lh_q) << (HW + 1)) + N_W'(pp_ll_q);

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q       <= e_d;
      f_q       <= f_d;
      g_q       <= g_d;
      ee_q      <= ee_d;
      ff_q      <= ff_d;
      ef_q      <= ef_d;
      gg_q      <= gg_d;
      a3_q      <= a3_d;
      l3_q      <= l3_d;
      g3_q      <= g3_d;
      d3_q      <= d3_d;
      a4_q      <= a3_q;
      l4_q      <= l3_q;
      direct4_q <= direct4_d;
      pp_ll_q   <= pp_ll_d;
      pp_lh_q   <= pp_lh_d;
      pp_hh_q   <= pp_hh_d;
      a5_q      <= a4_q;
      l5_q      <= l4_q;
      direct5_q <= direct4_q;
      n5_q      <= n5_d;
    end
  end

  assign ctl_o    = ctl5_q;
  assign a_o      = a5_q;
  assign l_o      = l5_q;
  assign direct_o = direct5_q;
  // d < l, so the upper half of d*d is already a valid partial remainder
  assign rem_o    = n5_q[N_W-1:SQ_W];
  assign nlow_o   = n5_q[SQ_W-1:0];

endmodule

/* rtl/core/psd_div_cell.sv */
// One restoring-division cell: resolves quotient bit K of d*d / l.
module psd_div_cell import psd_pkg::*; #(
  parameter int unsigned SQ_W = 66,
  parameter int unsigned K    = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  ctl_t            ctl_i,
  input  logic [SQ_W-1:0] a_i,
  input  logic [SQ_W-1:0] l_i,
  input  logic [SQ_W-1:0] direct_i,
  input  logic [SQ_W-1:0] rem_i,
  input  logic [SQ_W-1:0] nlow_i,
  input  logic [SQ_W-1:0] q_i,
  output ctl_t            ctl_o,
  output logic [SQ_W-1:0] a_o,
  output logic [SQ_W-1:0] l_o,
  output logic [SQ_W-1:0] direct_o,
  output logic [SQ_W-1:0] rem_o,
  output logic [SQ_W-1:0] nlow_o,
  output logic [SQ_W-1:0] q_o
);

  ctl_t            ctl_q;
  logic [SQ_W:0]   part;
  logic            ge;
  logic [SQ_W:0]   diff;
  logic [SQ_W-1:0] rem_d, q_d;
  logic [SQ_W-1:0] a_q, l_q, direct_q, rem_q, nlow_q, q_q;

  // shift in the next numerator bit, subtract the divisor if it fits
  assign part  = {rem_i, nlow_i[K]};
  assign ge    = (part >= {1'b0, l_i});
  assign diff  = part - {1'b0, l_i};
  assign rem_d = ge ? diff[SQ_W-1:0] : part[SQ_W-1:0];
  assign q_d   = q_i | (SQ_W'(ge) << K);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q      <= a_i;
      l_q      <= l_i;
      direct_q <= direct_i;
      rem_q    <= rem_d;
      nlow_q   <= nlow_i;
      q_q      <= q_d;
    end
  end

  assign ctl_o    = ctl_q;
  assign a_o      = a_q;
  assign l_o      = l_q;
  assign direct_o = direct_q;
  assign rem_o    = rem_q;
  assign nlow_o   = nlow_q;
  assign q_o      = q_q;

endmodule

/* rtl/core/psd_sqrt_cell.sv */
// One digit-by-digit square root cell: resolves root bit K.
module psd_sqrt_cell import psd_pkg::*; #(
  parameter int unsigned SQ_W = 66,
  parameter int unsigned RW   = 33,
  parameter int unsigned K    = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [SQ_W-1:0] rem_i,
  input  logic [RW-1:0]   root_i,
  output logic            valid_o,
  output logic [SQ_W-1:0] rem_o,
  output logic [RW-1:0]   root_o
);

  localparam int unsigned TW = SQ_W + 1;

  logic            valid_q;
  logic [TW-1:0]   trial;
  logic            ge;
  logic [SQ_W-1:0] rem_d, rem_q;
  logic [RW-1:0]   root_d, root_q;

  // (s + 2^K)^2 - s^2 = s*2^(K+1) + 2^(2K); s has no bits at or below K
  assign trial  = (TW'(root_i) << (K + 1)) | (TW'(1) << (2 * K));
  assign ge     = ({1'b0, rem_i} >= trial);
  assign rem_d  = ge ? (rem_i - trial[SQ_W-1:0]) : rem_i;
  assign root_d = root_i | (RW'(ge) << K);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule

/* rtl/core/point_segment_distance_3d_unit.sv */
// Top level: register port, distance pipeline of cells and output skid stage.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_stall_o    point_x_i, point_y_i, point_z_i
//   out      source     out_valid_o / out_stall_i  distance_o
//   cfg      sink       psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One transaction per cycle while in_stall_o is low; each result passes the front end,
// the division chain (one cell per quotient bit), the radicand register and the root chain.
// Reset clears all valid bits and the segment registers to zero.
// A stalled output holds its result; one more result parks in the skid stage,
// and only then does in_stall_o rise and the whole pipeline hold.
module point_segment_distance_3d_unit import psd_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           in_valid_i,
  output logic                                           in_stall_o,
  input  logic signed [COORD_BITS-1:0]                   point_x_i,
  input  logic signed [COORD_BITS-1:0]                   point_y_i,
  input  logic signed [COORD_BITS-1:0]                   point_z_i,
  output logic                                           out_valid_o,
  input  logic                                           out_stall_i,
  output logic [COORD_BITS:0]                            distance_o,
  input  logic                                           psel,
  input  logic                                           penable,
  input  logic                                           pwrite,
  input  logic [((COORD_BITS > 32) ? 3 : 2) + 2:0]       paddr,
  input  logic [((COORD_BITS > 32) ? 64 : 32)-1:0]       pwdata,
  output logic [((COORD_BITS > 32) ? 64 : 32)-1:0]       prdata,
  output logic                                           pready
);

  localparam int unsigned DATA_W = (COORD_BITS > 32) ? 64 : 32;
  localparam int unsigned STRIDE = (COORD_BITS > 32) ? 3 : 2;
  localparam int unsigned AW     = STRIDE + 3;
  localparam int unsigned SQ_W   = 2 * COORD_BITS + 2;
  localparam int unsigned RW     = COORD_BITS + 1;

  typedef enum logic [2:0] {
    REG_TOP_X    = 3'd0,
    REG_TOP_Y    = 3'd1,
    REG_TOP_Z    = 3'd2,
    REG_BOTTOM_X = 3'd3,
    REG_BOTTOM_Y = 3'd4,
    REG_BOTTOM_Z = 3'd5
  } reg_idx_e;

  // Register port
  logic                         cfg_wr;
  logic [2:0]                   reg_idx;
  logic signed [COORD_BITS-1:0] top_x_q, top_y_q, top_z_q;
  logic signed [COORD_BITS-1:0] bot_x_q, bot_y_q, bot_z_q;
  logic [COORD_BITS-1:0]        rd_val;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[AW-1:STRIDE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_x_q <= '0;
      top_y_q <= '0;
      top_z_q <= '0;
      bot_x_q <= '0;
      bot_y_q <= '0;
      bot_z_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TOP_X:    top_x_q <= pwdata[COORD_BITS-1:0];
        REG_TOP_Y:    top_y_q <= pwdata[COORD_BITS-1:0];
        REG_TOP_Z:    top_z_q <= pwdata[COORD_BITS-1:0];
        REG_BOTTOM_X: bot_x_q <= pwdata[COORD_BITS-1:0];
        REG_BOTTOM_Y: bot_y_q <= pwdata[COORD_BITS-1:0];
        REG_BOTTOM_Z: bot_z_q <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TOP_X:    rd_val = top_x_q;
      REG_TOP_Y:    rd_val = top_y_q;
      REG_TOP_Z:    rd_val = top_z_q;
      REG_BOTTOM_X: rd_val = bot_x_q;
      REG_BOTTOM_Y: rd_val = bot_y_q;
      REG_BOTTOM_Z: rd_val = bot_z_q;
      default:      rd_val = '0;
    endcase
  end

  assign prdata = DATA_W'(rd_val);

  // Pipeline advance: holds only when the skid stage is occupied
  logic out_valid_q, skid_valid_q;
  logic en;

  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Front end
  ctl_t            div_ctl    [SQ_W+1];
  logic [SQ_W-1:0] div_a      [SQ_W+1];
  logic [SQ_W-1:0] div_l      [SQ_W+1];
  logic [SQ_W-1:0] div_direct [SQ_W+1];
  logic [SQ_W-1:0] div_rem    [SQ_W+1];
  logic [SQ_W-1:0] div_nlow   [SQ_W+1];
  logic [SQ_W-1:0] div_q      [SQ_W+1];

  psd_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .top_x_i    (top_x_q),
    .top_y_i    (top_y_q),
    .top_z_i    (top_z_q),
    .bottom_x_i (bot_x_q),
    .bottom_y_i (bot_y_q),
    .bottom_z_i (bot_z_q),
    .ctl_o      (div_ctl[0]),
    .a_o        (div_a[0]),
    .l_o        (div_l[0]),
    .direct_o   (div_direct[0]),
    .rem_o      (div_rem[0]),
    .nlow_o     (div_nlow[0])
  );

  assign div_q[0] = '0;

  // Division chain, most significant quotient bit first
  for (genvar j = 0; j < SQ_W; j++) begin : g_div
    psd_div_cell #(
      .SQ_W (SQ_W),
      .K    (SQ_W - 1 - j)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .ctl_i    (div_ctl[j]),
      .a_i      (div_a[j]),
      .l_i      (div_l[j]),
      .direct_i (div_direct[j]),
      .rem_i    (div_rem[j]),
      .nlow_i   (div_nlow[j]),
      .q_i      (div_q[j]),
      .ctl_o    (div_ctl[j+1]),
      .a_o      (div_a[j+1]),
      .l_o      (div_l[j+1]),
      .direct_o (div_direct[j+1]),
      .rem_o    (div_rem[j+1]),
      .nlow_o   (div_nlow[j+1]),
      .q_o      (div_q[j+1])
    );
  end

  // Radicand: a - ceil(d*d / l), clamped at zero, or the direct square
  logic            round_up;
  logic [SQ_W:0]   rad_diff;
  logic [SQ_W-1:0] rad_d;
  logic            rad_valid_q;
  logic [SQ_W-1:0] rad_q;

  assign round_up = |div_rem[SQ_W];
  assign rad_diff = {1'b0, div_a[SQ_W]} - {1'b0, div_q[SQ_W]} - (SQ_W + 1)'(round_up);

  always_comb begin
    if (!div_ctl[SQ_W].sel_div) begin
      rad_d = div_direct[SQ_W];
    end else if (rad_diff[SQ_W]) begin
      rad_d = '0;
    end else begin
      rad_d = rad_diff[SQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_valid_q <= 1'b0;
    end else if (en) begin
      rad_valid_q <= div_ctl[SQ_W].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= rad_d;
    end
  end

  // Square root chain; the root always fits RW bits
  logic            sq_valid [RW+1];
  logic [SQ_W-1:0] sq_rem   [RW+1];
  logic [RW-1:0]   sq_root  [RW+1];

  assign sq_valid[0] = rad_valid_q;
  assign sq_rem[0]   = rad_q;
  assign sq_root[0]  = '0;

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    psd_sqrt_cell #(
      .SQ_W (SQ_W),
      .RW   (RW),
      .K    (RW - 1 - j)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[j]),
      .rem_i   (sq_rem[j]),
      .root_i  (sq_root[j]),
      .valid_o (sq_valid[j+1]),
      .rem_o   (sq_rem[j+1]),
      .root_o  (sq_root[j+1])
    );
  end

  // Output register with skid stage
  logic          take, incoming;
  logic [RW-1:0] out_q, skid_q;

  assign take     = out_valid_q && !out_stall_i;
  assign incoming = en && sq_valid[RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (incoming) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (incoming) begin
      if (!out_valid_q || take) begin
        out_q <= sq_root[RW];
      end else begin
        skid_q <= sq_root[RW];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = out_q;

`ifndef ASSERT_OFF
  // skid stage only fills behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage occupied without output result");

  // skid stage fills only when the output was held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid stage filled while output was free");

  // division leaves a partial remainder below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_ctl[SQ_W].valid && div_ctl[SQ_W].sel_div) |-> (div_rem[SQ_W] < div_l[SQ_W]))
    else $error("division remainder not below divisor");

  // root chain leaves a remainder below 2*root+1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid[RW] |-> ({1'b0, sq_rem[RW]} <= ((SQ_W + 1)'(sq_root[RW]) << 1)))
    else $error("square root remainder out of range");
`endif

endmodule
